[design/fdc_pkg.sv]
`timescale 1ns / 1ps

package fdc_pkg;

  // Defaults for the top-level parameters.
  localparam int DISK_ADDR_BITS_DEF = 24;
  localparam int SECTOR_BYTES_DEF   = 256;

  // Configuration port geometry.
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;

  // Configuration register indexes (byte address is four times the index).
  localparam logic [1:0] CFG_LAST_TRACK    = 2'd0;
  localparam logic [1:0] CFG_SECTORS       = 2'd1;
  localparam logic [1:0] CFG_WRITE_PROTECT = 2'd2;
  localparam logic [1:0] CFG_NOT_READY     = 2'd3;

  // Configuration reset values.
  localparam logic [7:0] LAST_TRACK_RST = 8'd79;
  localparam logic [7:0] SECTORS_RST    = 8'd18;

  // Processor-side register select codes.
  localparam logic [1:0] SEL_CMD    = 2'd0;
  localparam logic [1:0] SEL_TRACK  = 2'd1;
  localparam logic [1:0] SEL_SECTOR = 2'd2;
  localparam logic [1:0] SEL_DATA   = 2'd3;

  // Bus access kinds.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Command codes, taken from the upper nibble of a command write.
  localparam logic [3:0] CMD_RESTORE     = 4'h0;
  localparam logic [3:0] CMD_SEEK        = 4'h1;
  localparam logic [3:0] CMD_STEP        = 4'h2;
  localparam logic [3:0] CMD_STEP_U      = 4'h3;
  localparam logic [3:0] CMD_STEP_IN     = 4'h4;
  localparam logic [3:0] CMD_STEP_IN_U   = 4'h5;
  localparam logic [3:0] CMD_STEP_OUT    = 4'h6;
  localparam logic [3:0] CMD_STEP_OUT_U  = 4'h7;
  localparam logic [3:0] CMD_READ_SEC    = 4'h8;
  localparam logic [3:0] CMD_READ_SEC_M  = 4'h9;
  localparam logic [3:0] CMD_WRITE_SEC   = 4'hA;
  localparam logic [3:0] CMD_WRITE_SEC_M = 4'hB;
  localparam logic [3:0] CMD_READ_ADDR   = 4'hC;
  localparam logic [3:0] CMD_FORCE_INT   = 4'hD;

  // Bit of a Type I command that asks for a track register update.
  localparam int CMD_UPDATE_BIT = 4;

  // Status bits.
  localparam logic [7:0] ST_NOT_READY = 8'h80;
  localparam logic [7:0] ST_PROTECT   = 8'h40;
  localparam logic [7:0] ST_HEAD      = 8'h20;
  localparam logic [7:0] ST_TRACK0    = 8'h04;
  localparam logic [7:0] ST_BUSY_DRQ  = 8'h03;
  localparam logic [7:0] ST_CLR_BOTH  = 8'hFC;
  localparam logic [7:0] ST_CLR_DRQ   = 8'hFD;

  // Step direction left by the last step in or step out.
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_IN   = 2'd1,
    DIR_OUT  = 2'd2,
    DIR_ODD  = 2'd3
  } step_dir_t;

  // Configuration registers as seen by the core.
  typedef struct packed {
    logic [7:0] last_track;
    logic [7:0] sectors_per_track;
    logic       write_protected;
    logic       not_ready;
  } cfg_t;

  // One processor bus access.
  typedef struct packed {
    logic       operation;
    logic [1:0] register_select;
    logic [7:0] write_value;
    logic [7:0] disk_byte;
  } item_t;

  // One head step, saturating to 0..last.
  function automatic logic [7:0] clamp_step(input logic [7:0] t, input step_dir_t d,
                                            input logic [7:0] last);
    logic [7:0] v;
    unique case (d)
      DIR_IN:  v = (t >= last) ? last : t + 8'd1;
      DIR_OUT: v = (t == 8'd0) ? 8'd0 : t - 8'd1;
      default: v = t;
    endcase
    return (v > last) ? last : v;
  endfunction

endpackage

[design/fdc_cfg_regs.sv]
`timescale 1ns / 1ps

module fdc_cfg_regs import fdc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.last_track        <= LAST_TRACK_RST;
      cfg.sectors_per_track <= SECTORS_RST;
      cfg.write_protected   <= 1'b0;
      cfg.not_ready         <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        CFG_LAST_TRACK:    cfg.last_track        <= pwdata[7:0];
        CFG_SECTORS:       cfg.sectors_per_track <= pwdata[7:0];
        CFG_WRITE_PROTECT: cfg.write_protected   <= pwdata[0];
        CFG_NOT_READY:     cfg.not_ready         <= pwdata[0];
      endcase
    end
  end

  // Read-back of the selected register.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      CFG_LAST_TRACK:    prdata[7:0] = cfg.last_track;
      CFG_SECTORS:       prdata[7:0] = cfg.sectors_per_track;
      CFG_WRITE_PROTECT: prdata[0]   = cfg.write_protected;
      CFG_NOT_READY:     prdata[0]   = cfg.not_ready;
    endcase
  end

endmodule

[design/fdc_core.sv]
`timescale 1ns / 1ps

module fdc_core import fdc_pkg::*; #(
  parameter int DISK_ADDR_BITS = DISK_ADDR_BITS_DEF,
  parameter int SECTOR_BYTES   = SECTOR_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      exec,
  input  item_t                     item,
  input  cfg_t                      cfg,
  output logic [7:0]                read_value,
  output logic                      disk_write,
  output logic [DISK_ADDR_BITS-1:0] disk_write_addr,
  output logic [DISK_ADDR_BITS-1:0] transfer_addr,
  output logic                      transfer_active,
  output logic [7:0]                status
);

  localparam int AW = DISK_ADDR_BITS;

  // Controller state.
  logic [7:0]  status_reg, track_reg, sector_reg, data_reg, head_track;
  step_dir_t   step_direction;
  logic [AW-1:0] transfer_pos, transfer_end;
  logic          transfer_on;

  logic [7:0]  status_reg_next, track_reg_next, sector_reg_next, data_reg_next;
  logic [7:0]  head_track_next;
  step_dir_t   step_direction_next;
  logic [AW-1:0] transfer_pos_next, transfer_end_next;
  logic          transfer_on_next;

  // Sector window arithmetic for a read or write sector command.
  logic [15:0]   track_base;
  logic [AW-1:0] first_lin, end_lin, first_pos, multi_end;
  logic [7:0]    prot_bits;
  logic [7:0]    type1_stat;
  logic [7:0]    ht_sel;
  logic [AW-1:0] pos_inc;
  logic [3:0]    cmd;

  assign track_base = 16'(head_track) * 16'(cfg.sectors_per_track);
  assign first_lin  = AW'(track_base) + AW'(sector_reg) - AW'(1);
  assign end_lin    = AW'(track_base) + AW'(cfg.sectors_per_track);
  assign first_pos  = AW'(first_lin * SECTOR_BYTES);
  assign multi_end  = AW'(end_lin * SECTOR_BYTES);
  assign pos_inc    = transfer_pos + AW'(1);
  assign prot_bits  = (cfg.not_ready ? ST_NOT_READY : 8'h00) |
                      (cfg.write_protected ? ST_PROTECT : 8'h00);
  assign type1_stat = prot_bits | ST_HEAD | ((ht_sel == 8'd0) ? ST_TRACK0 : 8'h00);
  assign cmd        = item.write_value[7:4];

  // Next state and result of one bus access.
  always_comb begin
    status_reg_next     = status_reg;
    track_reg_next      = track_reg;
    sector_reg_next     = sector_reg;
    data_reg_next       = data_reg;
    head_track_next     = head_track;
    step_direction_next = step_direction;
    transfer_pos_next   = transfer_pos;
    transfer_end_next   = transfer_end;
    transfer_on_next    = transfer_on;
    read_value          = 8'h00;
    disk_write          = 1'b0;
    disk_write_addr     = '0;

    if (item.operation == OP_WRITE) begin
      unique case (item.register_select)
        SEL_CMD: begin
          unique case (cmd)
            CMD_RESTORE: begin
              track_reg_next = 8'd0;
            end
            CMD_SEEK: begin
              track_reg_next = ht_sel;
            end
            CMD_STEP, CMD_STEP_U: begin
              if (item.write_value[CMD_UPDATE_BIT])
                track_reg_next = clamp_step(track_reg, step_direction, cfg.last_track);
            end
            CMD_STEP_IN, CMD_STEP_IN_U: begin
              step_direction_next = DIR_IN;
              if (item.write_value[CMD_UPDATE_BIT] && track_reg < cfg.last_track)
                track_reg_next = track_reg + 8'd1;
            end
            CMD_STEP_OUT, CMD_STEP_OUT_U: begin
              step_direction_next = DIR_OUT;
              if (item.write_value[CMD_UPDATE_BIT] && track_reg > 8'd0)
                track_reg_next = track_reg - 8'd1;
            end
            CMD_READ_SEC, CMD_WRITE_SEC: begin
              transfer_pos_next = first_pos;
              transfer_end_next = first_pos + AW'(SECTOR_BYTES);
              transfer_on_next  = 1'b1;
              status_reg_next   = status_reg | ST_BUSY_DRQ;
            end
            CMD_READ_SEC_M, CMD_WRITE_SEC_M: begin
              transfer_pos_next = first_pos;
              transfer_end_next = multi_end;
              transfer_on_next  = (sector_reg <= cfg.sectors_per_track);
              status_reg_next   = status_reg | ST_BUSY_DRQ;
            end
            CMD_READ_ADDR: begin
              data_reg_next    = head_track;
              transfer_on_next = 1'b0;
            end
            CMD_FORCE_INT: begin
              status_reg_next  = status_reg & ST_CLR_DRQ;
              transfer_on_next = 1'b0;
            end
            default: begin
              transfer_on_next = 1'b0;
            end
          endcase
          // Type I commands rebuild the status from the new head track.
          if (cmd[3] == 1'b0) begin
            head_track_next  = ht_sel;
            status_reg_next  = type1_stat;
            transfer_on_next = 1'b0;
          end
        end
        SEL_TRACK:  track_reg_next  = item.write_value;
        SEL_SECTOR: sector_reg_next = item.write_value;
        SEL_DATA: begin
          data_reg_next = item.write_value;
          if (transfer_on) begin
            if (!cfg.write_protected) begin
              disk_write      = 1'b1;
              disk_write_addr = transfer_pos;
            end
            transfer_pos_next = pos_inc;
            if (pos_inc == transfer_end) begin
              transfer_on_next = 1'b0;
              status_reg_next  = status_reg & ST_CLR_BOTH;
            end
          end
        end
      endcase
    end else begin
      unique case (item.register_select)
        SEL_CMD:    read_value = status_reg;
        SEL_TRACK:  read_value = track_reg;
        SEL_SECTOR: read_value = sector_reg;
        SEL_DATA: begin
          if (transfer_on) begin
            data_reg_next     = item.disk_byte;
            transfer_pos_next = pos_inc;
            if (pos_inc == transfer_end) begin
              transfer_on_next = 1'b0;
              status_reg_next  = status_reg & ST_CLR_BOTH;
            end
          end
          read_value = data_reg_next;
        end
      endcase
    end

    transfer_addr   = transfer_pos_next;
    transfer_active = transfer_on_next;
  end

  // New head track for a Type I command.
  always_comb begin
    ht_sel = head_track;
    unique case (cmd)
      CMD_RESTORE:
        ht_sel = 8'd0;
      CMD_SEEK:
        ht_sel = (data_reg > cfg.last_track) ? cfg.last_track : data_reg;
      CMD_STEP, CMD_STEP_U:
        ht_sel = clamp_step(head_track, step_direction, cfg.last_track);
      CMD_STEP_IN, CMD_STEP_IN_U:
        if (head_track < cfg.last_track) ht_sel = head_track + 8'd1;
      CMD_STEP_OUT, CMD_STEP_OUT_U:
        if (head_track > 8'd0) ht_sel = head_track - 8'd1;
      default:
        ht_sel = head_track;
    endcase
  end

  // State update, once per executed access.
  always_ff @(posedge clk) begin
    if (rst) begin
      status_reg     <= 8'h00;
      track_reg      <= 8'h00;
      sector_reg     <= 8'h00;
      data_reg       <= 8'h00;
      head_track     <= 8'h00;
      step_direction <= DIR_NONE;
      transfer_pos   <= '0;
      transfer_end   <= '0;
      transfer_on    <= 1'b0;
    end else if (exec) begin
      status_reg     <= status_reg_next;
      track_reg      <= track_reg_next;
      sector_reg     <= sector_reg_next;
      data_reg       <= data_reg_next;
      head_track     <= head_track_next;
      step_direction <= step_direction_next;
      transfer_pos   <= transfer_pos_next;
      transfer_end   <= transfer_end_next;
      transfer_on    <= transfer_on_next;
    end
  end

  assign status = status_reg;

endmodule

[design/floppy_controller_registers.sv]
`timescale 1ns / 1ps

// Register front end of a floppy disk controller. Each input transfer is one
// processor access to the status/command, track, sector or data register; each
// produces exactly one result transfer carrying the read data, an optional disk
// memory write and the current sector window position. An access is captured in
// an input register, executed against the controller state and held in a result
// register, so one access is taken every clock cycle unless a stalled result
// register holds it off. The rate is set by the state update, whose longest path
// is the 8x8 track times sectors product that places the sector window. Disk
// configuration must be written over the APB port only while no access is in
// flight; the block itself does not enforce this.

module floppy_controller_registers import fdc_pkg::*; #(
  parameter int DISK_ADDR_BITS = DISK_ADDR_BITS_DEF,
  parameter int SECTOR_BYTES   = SECTOR_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // APB configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_ADDR_BITS-1:0]  paddr,
  input  logic [CFG_DATA_BITS-1:0]  pwdata,
  output logic [CFG_DATA_BITS-1:0]  prdata,
  output logic                      pready,
  // Access channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      operation,
  input  logic [1:0]                register_select,
  input  logic [7:0]                write_value,
  input  logic [7:0]                disk_byte,
  // Result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                read_value,
  output logic                      disk_write,
  output logic [DISK_ADDR_BITS-1:0] disk_write_addr,
  output logic [DISK_ADDR_BITS-1:0] transfer_addr,
  output logic                      transfer_active
);

  cfg_t  cfg;
  item_t item_q;
  logic  in_full;
  logic  exec;

  logic [7:0]                rd_c;
  logic                      dw_c;
  logic [DISK_ADDR_BITS-1:0] dwa_c, ta_c;
  logic                      act_c;
  logic [7:0]                status;

  fdc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // An access executes when the result register is free or being emptied.
  assign exec     = in_full & (~out_valid | out_ready);
  assign in_ready = ~in_full | exec;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q.operation       <= operation;
      item_q.register_select <= register_select;
      item_q.write_value     <= write_value;
      item_q.disk_byte       <= disk_byte;
    end
  end

  fdc_core #(
    .DISK_ADDR_BITS (DISK_ADDR_BITS),
    .SECTOR_BYTES   (SECTOR_BYTES)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .exec            (exec),
    .item            (item_q),
    .cfg             (cfg),
    .read_value      (rd_c),
    .disk_write      (dw_c),
    .disk_write_addr (dwa_c),
    .transfer_addr   (ta_c),
    .transfer_active (act_c),
    .status          (status)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      read_value      <= rd_c;
      disk_write      <= dw_c;
      disk_write_addr <= dwa_c;
      transfer_addr   <= ta_c;
      transfer_active <= act_c;
    end
  end

  // A full input register behind a stalled result must hold off new transfers.
  assert property (@(posedge clk) disable iff (rst)
    (in_full && out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while the result register is stalled");

  // A pending sector transfer always shows busy and data request.
  assert property (@(posedge clk) disable iff (rst)
    transfer_active && out_valid |-> (status[1:0] == ST_BUSY_DRQ[1:0]))
    else $error("transfer active without busy and data request");

  // The write address is zero unless a disk write is reported.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !disk_write) |-> (disk_write_addr == '0))
    else $error("disk write address set without a disk write");

endmodule
